// ----- src/spot_pkg.sv -----
package spot_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;

  localparam logic [2:0] CMD_POINT_CIRCLE  = 3'd0;
  localparam logic [2:0] CMD_RECT_CIRCLE   = 3'd1;
  localparam logic [2:0] CMD_CIRCLE_CIRCLE = 3'd2;
  localparam logic [2:0] CMD_POINT_OBOX    = 3'd3;
  localparam logic [2:0] CMD_CIRCLE_OBOX   = 3'd4;

  localparam logic [17:0] SIN_A = 18'd102944;
  localparam logic [17:0] SIN_B = 18'd42048;
  localparam logic [17:0] SIN_C = 18'd4640;
  localparam logic [17:0] ONE_Q16 = 18'd65536;

  // control that travels down the cell chain beside the payload
  typedef struct packed {
    logic       vld;
    logic [2:0] cmd;
  } ctl_t;

endpackage

// ----- src/spot_cell.sv -----
// one pipeline cell: register with load enable, loads whenever its output slot is free or moving
module spot_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  spot_pkg::ctl_t ctl_in,
  input  logic [W-1:0] data_in,
  output spot_pkg::ctl_t ctl_out,
  output logic [W-1:0] data_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl_out.cmd <= ctl_in.cmd;
      data_out    <= data_in;
    end
  end

endmodule

// ----- src/shape_pair_overlap_test_unit.sv -----
// shape pair overlap test
// s_axis carries one shape pair per request: tuser holds the pair kind
// (0 point-circle, 1 rect-circle, 2 circle-circle, 3 point-oriented,
// 4 circle-oriented, others answer 0), tdata the coordinates and sizes.
// m_axis returns one request per input with tdata bit 0 = hit.
// the work runs through a chain of eight identical register cells, each
// passing its request on whenever the next cell is free or moving:
// sine polynomial steps, rotation products, squaring and the final
// compare each sit between two cells.
// a pair moves through the cells in order and leaves from the last one;
// one pair is accepted every clock while the output is taken.
// when m_axis_tready is low the full cells hold, s_axis_tready drops
// only when every cell holds a request and the last one is not taken;
// an empty stage anywhere lets the chain close the gap.
// rst (synchronous, active high) empties the chain.
module shape_pair_overlap_test_unit #(
  parameter int COORD_BITS = spot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = spot_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius,
  // rect_right, rect_bottom, box_width, box_height, box_angle (low bit first)
  input  logic [((10*COORD_BITS-4+ANGLE_BITS)+7)/8*8-1:0] s_axis_tdata,
  // command
  input  logic [2:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit
  output logic [7:0] m_axis_tdata
);

  localparam int C = COORD_BITS;
  localparam int L = COORD_BITS - 1;
  localparam int A = ANGLE_BITS;
  localparam int D = C + 1;          // difference width
  localparam int P = D + 18;         // rotation product width
  localparam int R = P + 1;          // local coordinate width
  localparam int SQ = 2 * (C + 1);   // square width
  localparam int NST = 8;

  // input unpack
  logic signed [C-1:0] fx, fy, gx, gy, rr, rb;
  logic [L-1:0] fr, gr, bw, bh;
  logic [A-1:0] ang;
  assign fx  = s_axis_tdata[0*C +: C];
  assign fy  = s_axis_tdata[1*C +: C];
  assign fr  = s_axis_tdata[2*C +: L];
  assign gx  = s_axis_tdata[2*C+L +: C];
  assign gy  = s_axis_tdata[3*C+L +: C];
  assign gr  = s_axis_tdata[4*C+L +: L];
  assign rr  = s_axis_tdata[4*C+2*L +: C];
  assign rb  = s_axis_tdata[5*C+2*L +: C];
  assign bw  = s_axis_tdata[6*C+2*L +: L];
  assign bh  = s_axis_tdata[6*C+3*L +: L];
  assign ang = s_axis_tdata[6*C+4*L +: A];

  // stage payload, one common record carried by every cell
  typedef struct packed {
    logic signed [R-1:0] ax;   // x quantity (difference or local x)
    logic signed [R-1:0] ay;
    logic [C:0]          rad;  // radius (or radius sum)
    logic [L-1:0]        hw;
    logic [L-1:0]        hh;
    logic [1:0]          quad;
    logic [17:0]         za;   // z, then sin
    logic [17:0]         zb;   // 1-z, then cos
    logic [17:0]         ta;   // polynomial temporaries
    logic [17:0]         tb;
    logic [SQ:0]         sa;   // squares / sums
    logic [SQ:0]         sb;
    logic                far;
    logic                res;
  } pl_t;

  localparam int PW = $bits(pl_t);

  spot_pkg::ctl_t ctl_q [NST+1];
  logic [PW-1:0]  dat_q [1:NST];
  spot_pkg::ctl_t ctl_d [NST];
  pl_t            pin   [NST];
  pl_t            pout  [NST];
  logic           en    [NST];

  // adv[k]: the register behind cell k can load (free or moving on)
  logic adv [NST+1];
  assign adv[NST] = m_axis_tready || !ctl_q[NST].vld;
  genvar gi;
  generate
    for (gi = 0; gi < NST; gi++) begin : g_adv
      assign adv[gi] = adv[gi+1] || !ctl_q[gi+1].vld;
      assign en[gi]  = adv[gi];
    end
  endgenerate
  assign s_axis_tready = adv[0];

  assign ctl_q[0].vld = s_axis_tvalid;
  assign ctl_q[0].cmd = s_axis_tuser;

  function automatic logic [17:0] mul16(input logic [17:0] a, input logic [17:0] b);
    logic [35:0] m;
    begin
      m = a * b;
      return m[33:16];
    end
  endfunction

  function automatic logic [C:0] absd(input logic signed [R-1:0] v);
    logic signed [R-1:0] n;
    begin
      n = v < 0 ? -v : v;
      return n[C:0];
    end
  endfunction

  // stage 0: differences, clamp, quadrant, z
  always_comb begin
    logic signed [C-1:0] kx, ky;
    logic [A-3:0] zf;
    logic [17:0] z;
    pin[0] = '0;
    kx = (gx < fx) ? fx : ((gx > rr) ? rr : gx);
    ky = (gy < fy) ? fy : ((gy > rb) ? rb : gy);
    zf = ang[A-3:0];
    z  = 18'(({18'd0, zf} << 18) >> A);
    pin[0].hw = bw;
    pin[0].hh = bh;
    pin[0].quad = ang[A-1:A-2];
    pin[0].za = z;
    pin[0].zb = spot_pkg::ONE_Q16 - z;
    unique case (s_axis_tuser)
      spot_pkg::CMD_POINT_CIRCLE: begin
        pin[0].ax = R'(gx) - R'(fx);
        pin[0].ay = R'(gy) - R'(fy);
        pin[0].rad = {2'b00, gr};
      end
      spot_pkg::CMD_RECT_CIRCLE: begin
        pin[0].ax = R'(gx) - R'(kx);
        pin[0].ay = R'(gy) - R'(ky);
        pin[0].rad = {2'b00, gr};
      end
      spot_pkg::CMD_CIRCLE_CIRCLE: begin
        pin[0].ax = R'(fx) - R'(gx);
        pin[0].ay = R'(fy) - R'(gy);
        pin[0].rad = (C+1)'(fr) + (C+1)'(gr);
      end
      default: begin
        pin[0].ax = R'(fx) - R'(gx);
        pin[0].ay = R'(fy) - R'(gy);
        pin[0].rad = {2'b00, fr};
      end
    endcase
  end

  // stage 1: z^2 for both angles
  always_comb begin
    pin[1] = pout[0];
    pin[1].ta = mul16(pout[0].za, pout[0].za);
    pin[1].tb = mul16(pout[0].zb, pout[0].zb);
  end

  // stage 2: t = B - C*z2 (kept in sa/sb low bits for the z2 copy)
  always_comb begin
    pin[2] = pout[1];
    pin[2].sa = (SQ+1)'(pout[1].ta);
    pin[2].sb = (SQ+1)'(pout[1].tb);
    pin[2].ta = spot_pkg::SIN_B - mul16(spot_pkg::SIN_C, pout[1].ta);
    pin[2].tb = spot_pkg::SIN_B - mul16(spot_pkg::SIN_C, pout[1].tb);
  end

  // stage 3: u = A - z2*t
  always_comb begin
    pin[3] = pout[2];
    pin[3].ta = spot_pkg::SIN_A - mul16(pout[2].sa[17:0], pout[2].ta);
    pin[3].tb = spot_pkg::SIN_A - mul16(pout[2].sb[17:0], pout[2].tb);
  end

  // stage 4: s = z*u capped, then quadrant swap into za (sin) zb (cos) magnitudes
  always_comb begin
    logic [17:0] sz, cz;
    pin[4] = pout[3];
    sz = mul16(pout[3].za, pout[3].ta);
    cz = mul16(pout[3].zb, pout[3].tb);
    if (sz > spot_pkg::ONE_Q16) sz = spot_pkg::ONE_Q16;
    if (cz > spot_pkg::ONE_Q16) cz = spot_pkg::ONE_Q16;
    pin[4].za = pout[3].quad[0] ? cz : sz;
    pin[4].zb = pout[3].quad[0] ? sz : cz;
  end

  // stage 5: rotation (oriented kinds) or axis magnitudes
  always_comb begin
    logic signed [18:0] sn, cs;
    logic signed [D-1:0] dxs, dys;
    logic signed [R-1:0] pxs, pxc, pys, pyc;
    logic signed [R-1:0] lx, ly;
    logic [C:0] mx, my;
    pin[5] = pout[4];
    unique case (pout[4].quad)
      2'd0: begin sn =  19'(pout[4].za); cs =  19'(pout[4].zb); end
      2'd1: begin sn =  19'(pout[4].za); cs = -19'(pout[4].zb); end
      2'd2: begin sn = -19'(pout[4].za); cs = -19'(pout[4].zb); end
      default: begin sn = -19'(pout[4].za); cs = 19'(pout[4].zb); end
    endcase
    // differences fit D bits, so each product is D by 19
    dxs = pout[4].ax[D-1:0];
    dys = pout[4].ay[D-1:0];
    pxs = dxs * sn;
    pxc = dxs * cs;
    pys = dys * sn;
    pyc = dys * cs;
    lx = pxs - pyc;
    ly = pxc + pys;
    mx = absd(pout[4].ax);
    my = absd(pout[4].ay);
    if (ctl_q[5].cmd == spot_pkg::CMD_POINT_OBOX ||
        ctl_q[5].cmd == spot_pkg::CMD_CIRCLE_OBOX) begin
      pin[5].ax = lx;
      pin[5].ay = ly;
    end else begin
      pin[5].ax = R'(mx);
      pin[5].ay = R'(my);
    end
  end

  // stage 6: box test / edge distance, far check, squares
  always_comb begin
    logic signed [R-1:0] hw, hh, ox, oy;
    logic [R-1:0] ex, ey;
    logic [C:0] mx, my;
    pin[6] = pout[5];
    hw = R'({pout[5].hw, 15'd0});
    hh = R'({pout[5].hh, 15'd0});
    ox = pout[5].ax > hw ? pout[5].ax - hw : (pout[5].ax < -hw ? -hw - pout[5].ax : '0);
    oy = pout[5].ay > hh ? pout[5].ay - hh : (pout[5].ay < -hh ? -hh - pout[5].ay : '0);
    ex = (R'(ox) + R'(32768)) >> 16;
    ey = (R'(oy) + R'(32768)) >> 16;
    if (ctl_q[6].cmd == spot_pkg::CMD_CIRCLE_OBOX) begin
      pin[6].far = (ex > R'(pout[5].rad)) || (ey > R'(pout[5].rad));
      mx = (C+1)'(ex);
      my = (C+1)'(ey);
    end else begin
      pin[6].far = (pout[5].ax > R'(pout[5].rad)) || (pout[5].ay > R'(pout[5].rad));
      mx = pout[5].ax[C:0];
      my = pout[5].ay[C:0];
    end
    pin[6].res = ox == '0 && oy == '0;
    pin[6].sa = (SQ+1)'(mx * mx) + (SQ+1)'(my * my);
    pin[6].sb = (SQ+1)'(pout[5].rad * pout[5].rad);
  end

  // stage 7: final compare
  always_comb begin
    pin[7] = pout[6];
    unique case (ctl_q[7].cmd) inside
      spot_pkg::CMD_POINT_OBOX: pin[7].res = pout[6].res;
      spot_pkg::CMD_POINT_CIRCLE, spot_pkg::CMD_RECT_CIRCLE,
      spot_pkg::CMD_CIRCLE_CIRCLE, spot_pkg::CMD_CIRCLE_OBOX:
        pin[7].res = !pout[6].far && (pout[6].sa <= pout[6].sb);
      default: pin[7].res = 1'b0;
    endcase
  end

  generate
    for (gi = 0; gi < NST; gi++) begin : g_cell
      assign ctl_d[gi] = ctl_q[gi];
      if (gi > 0) begin : g_unp
        assign pout[gi-1] = pl_t'(dat_q[gi]);
      end
      spot_cell #(.W(PW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en[gi]),
        .ctl_in   (ctl_d[gi]),
        .data_in  (PW'(pin[gi])),
        .ctl_out  (ctl_q[gi+1]),
        .data_out (dat_q[gi+1])
      );
    end
  endgenerate
  assign pout[NST-1] = pl_t'(dat_q[NST]);

  assign m_axis_tvalid = ctl_q[NST].vld;
  assign m_axis_tdata  = {7'd0, pout[NST-1].res};

endmodule
